// ----- rtl/core/grd_pkg.sv -----
// Shared types, constants and helper functions for the gamepad report decoder.
// No dependencies; grd_front, grd_back and the top level in rtl/core import this package.
package grd_pkg;

	// Report ids and header lengths
	localparam logic [7:0] ID_FULL   = 8'h11;
	localparam logic [7:0] ID_BASIC  = 8'h01;
	localparam logic [6:0] HDR_FULL  = 7'd3;
	localparam logic [6:0] HDR_BASIC = 7'd1;

	// Byte position (zero based) that the last byte must reach
	localparam logic [6:0] MIN_POS_FULL  = 7'd44;
	localparam logic [6:0] MIN_POS_BASIC = 7'd42;
	localparam logic [6:0] MOTION_POS    = 7'd11;
	localparam logic [6:0] POS_MAX       = 7'd127;

	// Payload byte offsets
	localparam int PI_STICK = 0;
	localparam int PI_BTN0  = 4;
	localparam int PI_BTN1  = 5;
	localparam int PI_BTN2  = 6;
	localparam int PI_TRIG  = 7;
	localparam int PI_GYRO  = 12;
	localparam int PI_ACCEL = 18;
	localparam int PI_BATT  = 29;
	localparam int PI_TOUCH = 34;

	// Configuration
	localparam int         CFG_DATA_W       = 12;
	localparam logic       REG_SWIPE_CLAMP  = 1'b0;
	localparam logic       REG_CLICK_SPLIT  = 1'b1;
	localparam logic [10:0] SWIPE_CLAMP_RST = 11'd12;
	localparam logic [11:0] CLICK_SPLIT_RST = 12'd960;

	localparam int GRD_QUEUE_DEPTH = 2;

	// Raw report fields captured by the front end
	typedef struct packed {
		logic            kind;
		logic            motion;
		logic [3:0][7:0] stick;
		logic [7:0]      btn0;
		logic [7:0]      btn1;
		logic [7:0]      btn2;
		logic [1:0][7:0] trig;
		logic [5:0][7:0] gyro;
		logic [5:0][7:0] accel;
		logic [7:0]      batt;
		logic [7:0][7:0] touch;
	} rec_t;

	// Decoded result
	typedef struct packed {
		logic               report_kind;
		logic               motion_valid;
		logic [19:0]        button_bits;
		logic [31:0]        stick_axes;
		logic [15:0]        trigger_levels;
		logic [47:0]        gyro_axes;
		logic [47:0]        accel_axes;
		logic [6:0]         battery_percent;
		logic               charge_state;
		logic [24:0]        touch_first;
		logic [24:0]        touch_second;
		logic signed [11:0] swipe_delta;
	} result_t;

	// Map battery byte to {charging, percent}
	function automatic logic [7:0] battery_map(input logic cable, input logic [3:0] lvl);
		logic [6:0] pct;
		logic       chg;
		case (lvl)
			4'd0:    pct = 7'd5;
			4'd1:    pct = 7'd15;
			4'd2:    pct = 7'd25;
			4'd3:    pct = 7'd35;
			4'd4:    pct = 7'd45;
			4'd5:    pct = 7'd55;
			4'd6:    pct = 7'd65;
			4'd7:    pct = 7'd75;
			4'd8:    pct = 7'd85;
			4'd9:    pct = 7'd95;
			default: pct = 7'd100;
		endcase
		chg = 1'b0;
		if (cable) begin
			if (lvl <= 4'd10) begin
				chg = 1'b1;
			end else if (lvl >= 4'd12) begin
				pct = 7'd0;
			end
		end
		return {chg, pct};
	endfunction

	// Pack four touch bytes into {active, y, x}
	function automatic logic [24:0] touch_word(input logic [3:0][7:0] t);
		return {~t[0][7], t[3], t[2][7:4], t[2][3:0], t[1]};
	endfunction

endpackage

// ----- rtl/core/grd_fifo.sv -----
// Small register queue used between the decoder stages.
// Depends on nothing but its parameters.
module grd_fifo #(
	parameter int Width = 8,
	parameter int Depth = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [Width-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic             empty,
	output logic [Width-1:0] rdata
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	logic [Width-1:0] mem_q [Depth];
	logic [PtrW-1:0]  wr_ptr_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [CntW-1:0]  count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CntW'(Depth));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/core/grd_front.sv -----
// Front end: counts report bytes, captures payload fields, classifies the report.
// Depends on grd_pkg.
module grd_front
	import grd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	output logic       rec_push,
	output rec_t       rec
);

	logic [6:0] pos_q;
	logic [7:0] first_id_q;
	logic       motion_q;
	rec_t       fields_q;

	rec_t       fields_d;
	logic [7:0] id_now;
	logic [6:0] hdr;
	logic [6:0] pidx;
	logic [6:0] off;
	logic       is_full;
	logic       is_basic;
	logic       long_enough;
	logic       motion_d;

	always_comb begin
		id_now   = (pos_q == '0) ? data_byte : first_id_q;
		is_full  = (id_now == ID_FULL);
		is_basic = (id_now == ID_BASIC);
		hdr      = is_full ? HDR_FULL : HDR_BASIC;
		pidx     = pos_q - hdr;
		fields_d = fields_q;
		off      = '0;

		// Drop header bytes, steer payload bytes to their field
		if ((pos_q != '0) && (pos_q >= hdr)) begin
			if (pidx < 7'(PI_STICK + 4)) begin
				off = pidx - 7'(PI_STICK);
				fields_d.stick[off[1:0]] = data_byte;
			end else if (pidx == 7'(PI_BTN0)) begin
				fields_d.btn0 = data_byte;
			end else if (pidx == 7'(PI_BTN1)) begin
				fields_d.btn1 = data_byte;
			end else if (pidx == 7'(PI_BTN2)) begin
				fields_d.btn2 = data_byte;
			end else if (pidx >= 7'(PI_TRIG) && pidx < 7'(PI_TRIG + 2)) begin
				off = pidx - 7'(PI_TRIG);
				fields_d.trig[off[0]] = data_byte;
			end else if (pidx >= 7'(PI_GYRO) && pidx < 7'(PI_GYRO + 6)) begin
				off = pidx - 7'(PI_GYRO);
				fields_d.gyro[off[2:0]] = data_byte;
			end else if (pidx >= 7'(PI_ACCEL) && pidx < 7'(PI_ACCEL + 6)) begin
				off = pidx - 7'(PI_ACCEL);
				fields_d.accel[off[2:0]] = data_byte;
			end else if (pidx == 7'(PI_BATT)) begin
				fields_d.batt = data_byte;
			end else if (pidx >= 7'(PI_TOUCH) && pidx < 7'(PI_TOUCH + 8)) begin
				off = pidx - 7'(PI_TOUCH);
				fields_d.touch[off[2:0]] = data_byte;
			end
		end

		motion_d = motion_q | (last_byte && is_full && (pos_q >= MOTION_POS));
		long_enough = is_full ? (pos_q >= MIN_POS_FULL)
		                      : (is_basic && (pos_q >= MIN_POS_BASIC));

		fields_d.kind   = is_full;
		fields_d.motion = motion_d;
	end

	assign rec_push = accept && last_byte && long_enough;
	assign rec      = fields_d;

	always_ff @(posedge clk) begin
		if (accept) begin
			fields_q <= fields_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			first_id_q <= '0;
			motion_q   <= 1'b0;
		end else if (accept) begin
			if (pos_q == '0) begin
				first_id_q <= data_byte;
			end
			if (last_byte) begin
				pos_q    <= '0;
				motion_q <= motion_d;
			end else if (pos_q != POS_MAX) begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

endmodule

// ----- rtl/core/grd_back.sv -----
// Back end: decodes a captured report into the result layout, tracks finger one.
// Depends on grd_pkg.
module grd_back
	import grd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        rec_valid,
	input  rec_t        rec,
	output logic        rec_pop,
	input  logic        res_full,
	output logic        res_push,
	output result_t     res,
	input  logic [10:0] swipe_clamp,
	input  logic [11:0] click_split_x
);

	logic [11:0] prev_x_q;
	logic        track_q;

	logic [3:0]         hat;
	logic [19:0]        btn;
	logic [7:0]         batt_code;
	logic [11:0]        tx;
	logic               f1_active;
	logic               pad;
	logic signed [12:0] diff;
	logic signed [12:0] lim;
	logic signed [12:0] delta;

	assign rec_pop  = rec_valid && !res_full;
	assign res_push = rec_pop;

	always_comb begin
		hat       = rec.btn0[3:0];
		pad       = rec.btn2[1];
		tx        = {rec.touch[2][3:0], rec.touch[1]};
		f1_active = ~rec.touch[0][7];

		btn     = '0;
		btn[0]  = (hat == 4'd0) || (hat == 4'd1) || (hat == 4'd7);
		btn[1]  = (hat >= 4'd3) && (hat <= 4'd5);
		btn[2]  = (hat >= 4'd5) && (hat <= 4'd7);
		btn[3]  = (hat >= 4'd1) && (hat <= 4'd3);
		btn[4]  = rec.btn0[5];
		btn[5]  = rec.btn0[6];
		btn[6]  = rec.btn0[4];
		btn[7]  = rec.btn0[7];
		btn[15:8] = rec.btn1;
		btn[16] = rec.btn2[0];
		btn[17] = pad;
		btn[18] = pad && f1_active && (tx < click_split_x);
		btn[19] = pad && f1_active && !(tx < click_split_x);

		batt_code = battery_map(rec.batt[4], rec.batt[3:0]);

		// Clamp the x movement to +-swipe_clamp
		diff  = $signed({1'b0, tx}) - $signed({1'b0, prev_x_q});
		lim   = $signed({2'b00, swipe_clamp});
		delta = '0;
		if (f1_active && track_q) begin
			if (diff > lim) begin
				delta = lim;
			end else if (diff < -lim) begin
				delta = -lim;
			end else begin
				delta = diff;
			end
		end

		res.report_kind      = rec.kind;
		res.motion_valid     = rec.motion;
		res.button_bits      = btn;
		res.stick_axes       = rec.stick;
		res.trigger_levels   = rec.trig;
		res.gyro_axes        = rec.motion ? rec.gyro : '0;
		res.accel_axes       = rec.motion ? rec.accel : '0;
		res.battery_percent  = batt_code[6:0];
		res.charge_state     = batt_code[7];
		res.touch_first      = touch_word(rec.touch[3:0]);
		res.touch_second     = touch_word(rec.touch[7:4]);
		res.swipe_delta      = delta[11:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_x_q <= '0;
			track_q  <= 1'b0;
		end else if (rec_pop) begin
			track_q <= f1_active;
			if (f1_active) begin
				prev_x_q <= tx;
			end
		end
	end

endmodule

// ----- rtl/core/gamepad_report_decoder.sv -----
// Gamepad report decoder, top level: front end, report queue, back end, result queue.
// Depends on grd_pkg, grd_front, grd_fifo and grd_back.
// Throughput: one report byte per cycle while full is low; full is high only while the report queue is full.
// Path: the edge that accepts the last byte writes the report queue; with room in the result queue
// the back end decodes it combinationally and the next edge writes the result queue (empty low).
// Reset: clears byte count, id, motion flag, tracking, queues; config back to 12 / 960.
module gamepad_report_decoder
	import grd_pkg::*;
#(
	parameter int QueueDepth = GRD_QUEUE_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,

	// Byte request side
	input  logic                  push,
	output logic                  full,
	input  logic [7:0]            data_byte,
	input  logic                  last_byte,

	// Configuration writes
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,

	// Result request side
	output logic                  empty,
	input  logic                  pop,
	output logic                  report_kind,
	output logic                  motion_valid,
	output logic [19:0]           button_bits,
	output logic [31:0]           stick_axes,
	output logic [15:0]           trigger_levels,
	output logic [47:0]           gyro_axes,
	output logic [47:0]           accel_axes,
	output logic [6:0]            battery_percent,
	output logic                  charge_state,
	output logic [24:0]           touch_first,
	output logic [24:0]           touch_second,
	output logic signed [11:0]    swipe_delta
);

	logic [10:0] swipe_clamp_q;
	logic [11:0] click_split_q;

	logic        accept;
	logic        rec_push;
	rec_t        rec_in;
	rec_t        rec_out;
	logic        rec_full;
	logic        rec_empty;
	logic        rec_pop;
	logic        res_push;
	logic        res_full;
	result_t     res_in;
	result_t     res_out;

	// Hold off bytes while the report queue is full; a report only enters it on its
	// last byte, so this is conservative but keeps the front end simple.
	assign full   = rec_full;
	assign accept = push && !rec_full;

	// Configuration registers; the user must write them only while the decoder is idle, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			swipe_clamp_q <= SWIPE_CLAMP_RST;
			click_split_q <= CLICK_SPLIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SWIPE_CLAMP: swipe_clamp_q <= cfg_data[10:0];
				REG_CLICK_SPLIT: click_split_q <= cfg_data[11:0];
				default:         ;
			endcase
		end
	end

	// Front end: byte counting, header skip, field capture, length and id check
	grd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.rec_push  (rec_push),
		.rec       (rec_in)
	);

	// Queue of classified reports between front and back
	grd_fifo #(
		.Width ($bits(rec_t)),
		.Depth (QueueDepth)
	) u_rec_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (rec_push),
		.wdata  (rec_in),
		.full   (rec_full),
		.pop    (rec_pop),
		.empty  (rec_empty),
		.rdata  (rec_out)
	);

	// Back end: button, battery, touch and swipe decoding
	grd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.rec_valid     (!rec_empty),
		.rec           (rec_out),
		.rec_pop       (rec_pop),
		.res_full      (res_full),
		.res_push      (res_push),
		.res           (res_in),
		.swipe_clamp   (swipe_clamp_q),
		.click_split_x (click_split_q)
	);

	// Result queue; decouples the consumer from the decoder
	grd_fifo #(
		.Width ($bits(result_t)),
		.Depth (QueueDepth)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_in),
		.full   (res_full),
		.pop    (pop),
		.empty  (empty),
		.rdata  (res_out)
	);

	assign report_kind      = res_out.report_kind;
	assign motion_valid     = res_out.motion_valid;
	assign button_bits      = res_out.button_bits;
	assign stick_axes       = res_out.stick_axes;
	assign trigger_levels   = res_out.trigger_levels;
	assign gyro_axes        = res_out.gyro_axes;
	assign accel_axes       = res_out.accel_axes;
	assign battery_percent  = res_out.battery_percent;
	assign charge_state     = res_out.charge_state;
	assign touch_first      = res_out.touch_first;
	assign touch_second     = res_out.touch_second;
	assign swipe_delta      = res_out.swipe_delta;

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for gamepad_report_decoder: random and directed report bytes,
// a byte-level decode predictor in a scoreboard class, and random stalls on both queues.
// Depends on grd_pkg and the gamepad_report_decoder RTL only.
`timescale 1ns / 1ps

import grd_pkg::*;

localparam int PAYLOAD_BYTES = 42;
localparam int STORE_BYTES   = 45;
localparam int FULL_LEN      = 45;
localparam int BASIC_LEN     = 43;
localparam int MOTION_LEN    = 12;
localparam int MAX_SHOWN     = 40;

class report_checker;
	bit [6:0]    byte_count;
	bit [7:0]    rpt_id;
	bit [7:0]    store [STORE_BYTES];
	bit          motion_on;
	bit [11:0]   last_x;
	bit          tracking;
	bit [10:0]   clamp;
	bit [11:0]   split;
	result_t     expected_reports [$];
	int unsigned bytes_seen;
	int unsigned decoded;
	int unsigned dropped;
	int unsigned checked;
	int unsigned errors;

	function new();
		byte_count = '0;
		rpt_id     = '0;
		foreach (store[i]) store[i] = '0;
		motion_on  = 1'b0;
		last_x     = '0;
		tracking   = 1'b0;
		clamp      = 11'd12;
		split      = 12'd960;
	endfunction

	function void set_config(logic idx, logic [CFG_DATA_W-1:0] val);
		if (idx == REG_SWIPE_CLAMP) clamp = val[10:0];
		else split = val;
	endfunction

	function bit [24:0] pack_touch(bit [7:0] status, bit [7:0] lo, bit [7:0] mid, bit [7:0] hi);
		return {~status[7], hi, mid[7:4], mid[3:0], lo};
	endfunction

	// Take one accepted byte; on the last byte of a decodable report queue its result.
	function void take_byte(bit [7:0] b, bit last);
		bit [6:0]  pos;
		bit [6:0]  len;
		int        base;
		int        i;
		bit [7:0]  p [PAYLOAD_BYTES];
		bit [3:0]  hat;
		bit [3:0]  lvl;
		bit [11:0] tx;
		bit        pad;
		bit        finger;
		int        delta;
		result_t   want;
		bytes_seen++;
		pos = byte_count;
		len = (pos < POS_MAX) ? pos + 7'd1 : POS_MAX;
		if (pos < STORE_BYTES) store[pos] = b;
		if (pos == 0) rpt_id = b;
		if (!last) begin
			byte_count = len;
			return;
		end
		byte_count = '0;
		if (rpt_id == ID_FULL) begin
			if (len >= MOTION_LEN) motion_on = 1'b1;
			if (len < FULL_LEN) begin
				dropped++;
				return;
			end
			base = int'(HDR_FULL);
		end else if (rpt_id == ID_BASIC) begin
			if (len < BASIC_LEN) begin
				dropped++;
				return;
			end
			base = int'(HDR_BASIC);
		end else begin
			dropped++;
			return;
		end
		for (i = 0; i < PAYLOAD_BYTES; i++) p[i] = store[base + i];

		want = '0;
		want.report_kind  = (rpt_id == ID_FULL);
		want.motion_valid = motion_on;

		hat = p[PI_BTN0][3:0];
		want.button_bits[0]    = (hat == 4'd0) || (hat == 4'd1) || (hat == 4'd7);
		want.button_bits[1]    = (hat >= 4'd3) && (hat <= 4'd5);
		want.button_bits[2]    = (hat >= 4'd5) && (hat <= 4'd7);
		want.button_bits[3]    = (hat >= 4'd1) && (hat <= 4'd3);
		want.button_bits[4]    = p[PI_BTN0][5];
		want.button_bits[5]    = p[PI_BTN0][6];
		want.button_bits[6]    = p[PI_BTN0][4];
		want.button_bits[7]    = p[PI_BTN0][7];
		want.button_bits[15:8] = p[PI_BTN1];
		want.button_bits[16]   = p[PI_BTN2][0];
		pad = p[PI_BTN2][1];
		want.button_bits[17]   = pad;

		for (i = 0; i < 4; i++) want.stick_axes[8*i +: 8] = p[PI_STICK + i];
		want.trigger_levels = {p[PI_TRIG + 1], p[PI_TRIG]};
		if (motion_on) begin
			for (i = 0; i < 6; i++) begin
				want.gyro_axes[8*i +: 8]  = p[PI_GYRO + i];
				want.accel_axes[8*i +: 8] = p[PI_ACCEL + i];
			end
		end

		lvl = p[PI_BATT][3:0];
		if (p[PI_BATT][4]) begin
			if (lvl < 4'd10) begin
				want.battery_percent = 7'(lvl * 10 + 5);
				want.charge_state    = 1'b1;
			end else if (lvl == 4'd10) begin
				want.battery_percent = 7'd100;
				want.charge_state    = 1'b1;
			end else if (lvl == 4'd11) begin
				want.battery_percent = 7'd100;
			end
		end else begin
			want.battery_percent = (lvl < 4'd10) ? 7'(lvl * 10 + 5) : 7'd100;
		end

		tx     = {p[PI_TOUCH + 2][3:0], p[PI_TOUCH + 1]};
		finger = !p[PI_TOUCH][7];
		if (pad && finger) begin
			if (tx < split) want.button_bits[18] = 1'b1;
			else want.button_bits[19] = 1'b1;
		end
		if (finger) begin
			if (tracking) begin
				delta = int'(tx) - int'(last_x);
				if (delta > int'(clamp)) delta = int'(clamp);
				if (delta < -int'(clamp)) delta = -int'(clamp);
				want.swipe_delta = delta[11:0];
			end
			last_x   = tx;
			tracking = 1'b1;
		end else begin
			tracking = 1'b0;
		end
		want.touch_first  = pack_touch(p[PI_TOUCH], p[PI_TOUCH + 1], p[PI_TOUCH + 2],
			p[PI_TOUCH + 3]);
		want.touch_second = pack_touch(p[PI_TOUCH + 4], p[PI_TOUCH + 5], p[PI_TOUCH + 6],
			p[PI_TOUCH + 7]);

		expected_reports.push_back(want);
		decoded++;
	endfunction

	function void compare_field(string name, logic [63:0] want, logic [63:0] seen);
		if (seen !== want) begin
			errors++;
			if (errors <= MAX_SHOWN)
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, seen);
		end
	endfunction

	function void check_report(result_t seen);
		result_t want;
		if (expected_reports.size() == 0) begin
			errors++;
			if (errors <= MAX_SHOWN)
				$display("%0t: result with no report pending, expected none, actual %h",
					$time, seen);
			return;
		end
		want = expected_reports.pop_front();
		checked++;
		compare_field("report_kind", want.report_kind, seen.report_kind);
		compare_field("motion_valid", want.motion_valid, seen.motion_valid);
		compare_field("button_bits", want.button_bits, seen.button_bits);
		compare_field("stick_axes", want.stick_axes, seen.stick_axes);
		compare_field("trigger_levels", want.trigger_levels, seen.trigger_levels);
		compare_field("gyro_axes", want.gyro_axes, seen.gyro_axes);
		compare_field("accel_axes", want.accel_axes, seen.accel_axes);
		compare_field("battery_percent", want.battery_percent, seen.battery_percent);
		compare_field("charge_state", want.charge_state, seen.charge_state);
		compare_field("touch_first", want.touch_first, seen.touch_first);
		compare_field("touch_second", want.touch_second, seen.touch_second);
		compare_field("swipe_delta", {want.swipe_delta}, {seen.swipe_delta});
	endfunction
endclass

module tb_top;

	// Timeout is far above the slowest legal run (every byte after a long gap,
	// every result after a long stall, plus the forced hold-off).
	localparam int unsigned CYCLE_LIMIT   = 1500000;
	// Margin after the last expected result is out; gives dropped reports room too.
	localparam int unsigned SETTLE_CYCLES = 6;
	localparam int unsigned HOLD_CYCLES   = 600;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  push = 1'b0;
	logic                  full;
	logic [7:0]            data_byte = '0;
	logic                  last_byte = 1'b0;
	logic                  cfg_we = 1'b0;
	logic                  cfg_index = REG_SWIPE_CLAMP;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  empty;
	logic                  pop = 1'b0;
	logic                  report_kind;
	logic                  motion_valid;
	logic [19:0]           button_bits;
	logic [31:0]           stick_axes;
	logic [15:0]           trigger_levels;
	logic [47:0]           gyro_axes;
	logic [47:0]           accel_axes;
	logic [6:0]            battery_percent;
	logic                  charge_state;
	logic [24:0]           touch_first;
	logic [24:0]           touch_second;
	logic signed [11:0]    swipe_delta;

	report_checker sb = new();

	// Payload scratch for the report being built, plus generator state
	bit [7:0]    pl [PAYLOAD_BYTES];
	bit [11:0]   gen_x;
	bit [11:0]   cur_split = 12'd960;
	bit          tx_steady;
	bit          rx_steady;
	bit          hold_off_req;
	int unsigned cycle_count;
	int unsigned full_cycles;
	result_t     seen;

	gamepad_report_decoder u_dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 0;
	end

	// Watchdog: a hung handshake or a missing result ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles, %0d results still pending", $time,
				cycle_count, sb.expected_reports.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Sample both handshakes on the edge; values read here are the pre-edge ones,
	// the same ones the block acts on.
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full) sb.take_byte(data_byte, last_byte);
			if (push && full) full_cycles++;
			if (pop && !empty) begin
				seen = {report_kind, motion_valid, button_bits, stick_axes, trigger_levels,
					gyro_axes, accel_axes, battery_percent, charge_state, touch_first,
					touch_second, swipe_delta};
				sb.check_report(seen);
			end
		end
	end

	// Mostly no gap, some short, a few long; steady mode removes idling altogether.
	function automatic int unsigned pick_gap(bit steady);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (steady || r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Result side: random pop gaps, and on request one long hold-off counted here.
	initial begin : result_side
		int unsigned gap;
		forever begin
			if (hold_off_req) begin
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
			end else begin
				gap = pick_gap(rx_steady);
				if (gap != 0) begin
					pop <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				pop <= 1'b1;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
	end

	// Offer one byte request after a random gap and hold it until accepted.
	// Push stays high on return so back-to-back bytes need no extra assignment.
	task automatic send_byte(bit [7:0] b, bit last);
		int unsigned gap;
		gap = pick_gap(tx_steady);
		if (gap != 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push      <= 1'b1;
		data_byte <= b;
		last_byte <= last;
		do @(posedge clk); while (full);
	endtask

	// Send a report of len bytes: id, header filler for id 0x11, the payload scratch,
	// then random trailing bytes. A short len cuts the payload off.
	task automatic send_report(bit [7:0] id, int unsigned len);
		int unsigned hdr;
		int unsigned i;
		bit [7:0]    b;
		hdr = (id == ID_FULL) ? int'(HDR_FULL) : int'(HDR_BASIC);
		for (i = 0; i < len; i++) begin
			if (i == 0) b = id;
			else if (i < hdr) b = 8'($urandom);
			else if (i - hdr < PAYLOAD_BYTES) b = pl[i - hdr];
			else b = 8'($urandom);
			send_byte(b, i == len - 1);
		end
	endtask

	task automatic set_finger(bit down, bit [11:0] x);
		pl[PI_TOUCH][7]        = !down;
		pl[PI_TOUCH + 1]       = x[7:0];
		pl[PI_TOUCH + 2][3:0]  = x[11:8];
		gen_x = x;
	endtask

	// Random payload; keep finger one down most of the time so swipes chain, and
	// steer x near the last x or right at the click split now and then.
	task automatic random_payload();
		bit [11:0] x;
		foreach (pl[i]) pl[i] = 8'($urandom);
		case ($urandom_range(0, 3))
			0: x = gen_x + 12'($urandom_range(0, 60)) - 12'd30;
			1: x = cur_split - 12'($urandom_range(0, 1));
			default: x = 12'($urandom);
		endcase
		set_finger($urandom_range(0, 3) != 0, x);
	endtask

	// Mostly well-formed reports with random content; the rest short, unknown or long.
	task automatic random_report();
		int unsigned r;
		int unsigned extra;
		bit [7:0]    id;
		r     = $urandom_range(0, 99);
		extra = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 8) : 0;
		random_payload();
		if (r < 50) send_report(ID_FULL, FULL_LEN + extra);
		else if (r < 72) send_report(ID_BASIC, BASIC_LEN + extra);
		else if (r < 80) send_report(ID_FULL, $urandom_range(1, FULL_LEN - 1));
		else if (r < 86) send_report(ID_BASIC, $urandom_range(1, BASIC_LEN - 1));
		else if (r < 96) begin
			do id = 8'($urandom); while (id == ID_FULL || id == ID_BASIC);
			send_report(id, $urandom_range(1, 60));
		end else begin
			send_report(($urandom_range(0, 1) != 0) ? ID_FULL : ID_BASIC,
				$urandom_range(128, 140));
		end
	endtask

	// Drop push, then hold until every expected result is out and the pipe is quiet.
	task automatic settle();
		push <= 1'b0;
		@(posedge clk);
		while (sb.expected_reports.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write both registers on consecutive edges; the enable stays high across them.
	task automatic write_settings(bit [10:0] clamp, bit [11:0] split);
		cfg_we    <= 1'b1;
		cfg_index <= REG_SWIPE_CLAMP;
		cfg_data  <= CFG_DATA_W'(clamp);
		@(posedge clk);
		sb.set_config(REG_SWIPE_CLAMP, CFG_DATA_W'(clamp));
		cfg_index <= REG_CLICK_SPLIT;
		cfg_data  <= split;
		@(posedge clk);
		sb.set_config(REG_CLICK_SPLIT, split);
		cfg_we    <= 1'b0;
		cur_split = split;
	endtask

	initial begin : stimulus
		int          k;
		int unsigned ph;
		int unsigned need;
		int unsigned dec_mark;
		bit [10:0]   clamp;
		bit [11:0]   split;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, reset settings (clamp 12, split 960).
		// Basic reports before any motion: gyro and accel must read zero.
		random_payload();
		set_finger(1'b1, 12'd100);
		pl[PI_BTN0][3:0] = 4'd8;
		send_report(ID_BASIC, BASIC_LEN);
		random_payload();
		set_finger(1'b1, 12'd3000);
		send_report(ID_BASIC, BASIC_LEN);
		random_payload();
		set_finger(1'b1, 12'd0);
		send_report(ID_BASIC, BASIC_LEN);
		// Unknown id, one-byte report, basic one byte short: all give nothing.
		send_report(8'h22, FULL_LEN);
		send_report(ID_BASIC, 1);
		send_report(ID_BASIC, BASIC_LEN - 1);
		// Full report just under the motion length leaves the flag clear.
		send_report(ID_FULL, MOTION_LEN - 1);
		random_payload();
		send_report(ID_BASIC, BASIC_LEN);
		// Short full report at the motion length sets the sticky flag for basic too.
		send_report(ID_FULL, MOTION_LEN);
		random_payload();
		send_report(ID_BASIC, BASIC_LEN);
		// A report long enough to saturate the byte count.
		random_payload();
		send_report(ID_FULL, 130);
		// Walk hat values 0..7 and battery levels 8..15 (cable in up to level 13), with
		// pad click on either side of the split; the first payload is all zeros, the
		// last all ones with finger one lifted.
		for (k = 0; k < 8; k++) begin
			if (k == 0) foreach (pl[i]) pl[i] = 8'h00;
			else if (k == 7) foreach (pl[i]) pl[i] = 8'hff;
			else random_payload();
			pl[PI_BTN0][3:0] = 4'(k);
			pl[PI_BATT]      = {3'b000, k < 6, 4'(k + 8)};
			pl[PI_BTN2][1]   = 1'b1;
			set_finger(k != 7, k[0] ? 12'd960 : 12'd959);
			send_report(ID_BASIC, BASIC_LEN);
		end
		settle();

		// Random phases, each under its own register settings.
		for (ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin clamp = 11'd0;    split = 12'd0;    end
				1: begin clamp = 11'd2047; split = 12'd4095; end
				2: begin clamp = 11'd1;    split = 12'd1;    end
				default: begin
					clamp = 11'($urandom);
					split = 12'($urandom);
				end
			endcase
			write_settings(clamp, split);
			// Phase 1: hold the result side off while bytes keep coming, so the
			// queues fill and full stalls the sender. Phase 2: no idling at all.
			tx_steady    = (ph == 1) || (ph == 2);
			rx_steady    = (ph == 2);
			hold_off_req = (ph == 1);
			need         = (ph == 1) ? 5 : 2;
			dec_mark     = sb.decoded;
			while (sb.decoded - dec_mark < need)
				random_report();
			tx_steady = 1'b0;
			rx_steady = 1'b0;
			settle();
		end

		$display("covered %0d report bytes: %0d reports decoded and checked, %0d dropped",
			sb.bytes_seen, sb.checked, sb.dropped);
		$display("five register settings incl. both extremes; input stalled %0d cycles",
			full_cycles);
		if (sb.errors == 0 && sb.expected_reports.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/grd_pkg.sv
rtl/core/grd_fifo.sv
rtl/core/grd_front.sv
rtl/core/grd_back.sv
rtl/core/gamepad_report_decoder.sv
tb/tb_top.sv
